/* rtl/lpur_pkg.sv */
package lpur_pkg;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_LONG  = 3'd1;
  localparam logic [2:0] ST_TRUNCATED = 3'd2;
  localparam logic [2:0] ST_BAD_UTF8  = 3'd3;
  localparam logic [2:0] ST_NUL       = 3'd4;

  // UTF-8 byte class bounds
  localparam logic [7:0] ASCII_MAX   = 8'h7F;
  localparam logic [7:0] LEAD2_MIN   = 8'hC2;
  localparam logic [7:0] LEAD2_MAX   = 8'hDF;
  localparam logic [7:0] LEAD_E0     = 8'hE0;
  localparam logic [7:0] LEAD_ED     = 8'hED;
  localparam logic [7:0] LEAD_F0     = 8'hF0;
  localparam logic [7:0] LEAD_F4     = 8'hF4;
  localparam logic [7:0] E0_SEC_MIN  = 8'hA0;
  localparam logic [7:0] ED_SEC_MAX  = 8'h9F;
  localparam logic [7:0] F0_SEC_MIN  = 8'h90;
  localparam logic [7:0] F4_SEC_MAX  = 8'h8F;

  localparam logic [16:0] HEADER_BYTES = 17'd2;
  localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

  // Extra bound on the second byte of a multi-byte sequence
  typedef enum logic [2:0] {
    RULE_NONE,
    RULE_E0,
    RULE_ED,
    RULE_F0,
    RULE_F4
  } rule_t;

  typedef struct packed {
    logic [1:0] cont_left;
    rule_t      rule;
    logic       err_utf8;
    logic       err_nul;
  } utf8_state_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        record_end;
    logic [2:0]  status;
    logic [15:0] record_length;
    logic [16:0] bytes_used;
  } result_t;

endpackage

/* rtl/lpur_utf8_chk.sv */
module lpur_utf8_chk (
  input  logic [7:0]           data_byte,
  input  lpur_pkg::utf8_state_t cur,
  output lpur_pkg::utf8_state_t nxt
);
  import lpur_pkg::*;

  logic bad;

  always_comb begin
    nxt = cur;
    bad = 1'b0;
    if (data_byte == 8'h00) begin
      nxt.err_nul = 1'b1;
    end
    // decoding stops after the first malformed sequence
    if (!cur.err_utf8) begin
      if (cur.cont_left == 2'd0) begin
        nxt.rule = RULE_NONE;
        if (data_byte <= ASCII_MAX) begin
          nxt.cont_left = 2'd0;
        end else if (data_byte >= LEAD2_MIN && data_byte <= LEAD2_MAX) begin
          nxt.cont_left = 2'd1;
        end else if (data_byte[7:4] == LEAD_E0[7:4]) begin
          nxt.cont_left = 2'd2;
          if (data_byte == LEAD_E0) begin
            nxt.rule = RULE_E0;
          end else if (data_byte == LEAD_ED) begin
            nxt.rule = RULE_ED;
          end
        end else if (data_byte >= LEAD_F0 && data_byte <= LEAD_F4) begin
          nxt.cont_left = 2'd3;
          if (data_byte == LEAD_F0) begin
            nxt.rule = RULE_F0;
          end else if (data_byte == LEAD_F4) begin
            nxt.rule = RULE_F4;
          end
        end else begin
          nxt.err_utf8 = 1'b1;
        end
      end else begin
        bad = (data_byte[7:6] != 2'b10);
        unique case (cur.rule)
          RULE_E0: if (data_byte < E0_SEC_MIN) bad = 1'b1;
          RULE_ED: if (data_byte > ED_SEC_MAX) bad = 1'b1;
          RULE_F0: if (data_byte < F0_SEC_MIN) bad = 1'b1;
          RULE_F4: if (data_byte > F4_SEC_MAX) bad = 1'b1;
          default: ;
        endcase
        nxt.rule = RULE_NONE;
        if (bad) begin
          nxt.err_utf8  = 1'b1;
          nxt.cont_left = 2'd0;
        end else begin
          nxt.cont_left = cur.cont_left - 2'd1;
        end
      end
    end
  end

endmodule

/* rtl/lpur_out_buf.sv */
module lpur_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lpur_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output lpur_pkg::result_t head
);
  import lpur_pkg::*;

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("push into full result buffer");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("result buffer count out of range");
  a_head_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(head))
    else $error("stalled result changed");

endmodule

/* rtl/lpur_ctrl.sv */
module lpur_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              end_of_data,
  input  logic [15:0]       max_string_bytes,
  output logic              res_valid,
  output lpur_pkg::result_t res
);
  import lpur_pkg::*;

  typedef enum logic [1:0] {
    PH_LOW,
    PH_HIGH,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  hdr_low, hdr_low_next;
  logic [15:0] length, length_next;
  logic [15:0] count, count_next;
  utf8_state_t ustate, ustate_next, uchk;
  logic [15:0] hdr_len;

  lpur_utf8_chk u_chk (
    .data_byte (in_byte),
    .cur       (ustate),
    .nxt       (uchk)
  );

  assign hdr_len = {in_byte, hdr_low};

  always_comb begin
    phase_next   = phase;
    hdr_low_next = hdr_low;
    length_next  = length;
    count_next   = count;
    ustate_next  = ustate;
    res_valid    = 1'b0;
    res          = '0;
    unique case (phase)
      PH_LOW: begin
        hdr_low_next = in_byte;
        if (end_of_data) begin
          res_valid      = 1'b1;
          res.record_end = 1'b1;
          res.status     = ST_TRUNCATED;
        end else begin
          phase_next = PH_HIGH;
        end
      end
      PH_HIGH: begin
        length_next = hdr_len;
        count_next  = '0;
        ustate_next = '{cont_left: 2'd0, rule: RULE_NONE, err_utf8: 1'b0, err_nul: 1'b0};
        if (hdr_len > max_string_bytes) begin
          phase_next        = end_of_data ? PH_LOW : PH_DISCARD;
          res_valid         = 1'b1;
          res.record_end    = 1'b1;
          res.status        = ST_TOO_LONG;
          res.record_length = hdr_len;
        end else if (hdr_len == 16'd0) begin
          phase_next     = PH_LOW;
          res_valid      = 1'b1;
          res.record_end = 1'b1;
          res.status     = ST_OK;
          res.bytes_used = HEADER_BYTES;
        end else if (end_of_data) begin
          phase_next        = PH_LOW;
          res_valid         = 1'b1;
          res.record_end    = 1'b1;
          res.status        = ST_TRUNCATED;
          res.record_length = hdr_len;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        ustate_next       = uchk;
        count_next        = count + 16'd1;
        res_valid         = 1'b1;
        res.payload_byte  = in_byte;
        res.payload_valid = 1'b1;
        if (count_next == length) begin
          phase_next        = PH_LOW;
          res.record_end    = 1'b1;
          res.record_length = length;
          res.bytes_used    = {1'b0, length} + HEADER_BYTES;
          if (uchk.err_nul) begin
            res.status = ST_NUL;
          end else if (uchk.err_utf8 || uchk.cont_left != 2'd0) begin
            res.status = ST_BAD_UTF8;
          end else begin
            res.status = ST_OK;
          end
        end else if (end_of_data) begin
          phase_next        = PH_LOW;
          res.record_end    = 1'b1;
          res.status        = ST_TRUNCATED;
          res.record_length = length;
        end
      end
      PH_DISCARD: begin
        if (end_of_data) phase_next = PH_LOW;
      end
      default: phase_next = PH_LOW;
    endcase
    if (!accept) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_LOW;
      hdr_low <= '0;
      length  <= '0;
      count   <= '0;
      ustate  <= '{cont_left: 2'd0, rule: RULE_NONE, err_utf8: 1'b0, err_nul: 1'b0};
    end else if (accept) begin
      phase   <= phase_next;
      hdr_low <= hdr_low_next;
      length  <= length_next;
      count   <= count_next;
      ustate  <= ustate_next;
    end
  end

  a_payload_only_in_payload: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.payload_valid |-> phase == PH_PAYLOAD)
    else $error("payload result outside payload phase");
  a_count_below_len: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> count < length)
    else $error("payload count reached length without closing record");
  a_consumed_when_whole: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.bytes_used != 17'd0 |->
      res.status == ST_OK || res.status == ST_BAD_UTF8 || res.status == ST_NUL)
    else $error("bytes consumed on incomplete record");

endmodule

/* rtl/length_prefixed_utf8_string_reader_top.sv */
// Length-prefixed UTF-8 string reader: 2-byte LE header, then payload bytes.
// Each result is registered in the result buffer, which drives out_valid.
// Throughput: one byte per cycle; a two-entry result buffer keeps input open
//   while one finished result waits, so in_stall rises only when both are held.
// Reset (rst, synchronous): parser returns to the low header byte, buffer
//   empties, max_string_bytes returns to 65535.
module length_prefixed_utf8_string_reader_top (
  input  logic        clk,
  input  logic        rst,
  // configuration: max_string_bytes
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // input byte stream
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_data,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  payload_byte,
  output logic        payload_valid,
  output logic        record_end,
  output logic [2:0]  status,
  output logic [15:0] record_length,
  output logic [16:0] bytes_used
);
  import lpur_pkg::*;

  logic [15:0] max_string_bytes;
  logic        accept;
  logic        res_valid;
  result_t     res;
  result_t     head;
  logic        buf_full;

  // Length limit; checked once per record, on the high header byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_string_bytes <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_string_bytes <= cfg_wr_data;
    end
  end

  // An item is taken whenever the buffer has a free slot; bytes that
  // produce no result (low header byte without end_of_data, discarded bytes) push nothing.
  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  // Parser: header phases, payload counting, UTF-8/NUL checks, status.
  lpur_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .in_byte          (in_byte),
    .end_of_data      (end_of_data),
    .max_string_bytes (max_string_bytes),
    .res_valid        (res_valid),
    .res              (res)
  );

  // Result buffer separates the two handshakes.
  lpur_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign payload_byte  = head.payload_byte;
  assign payload_valid = head.payload_valid;
  assign record_end    = head.record_end;
  assign status        = head.status;
  assign record_length = head.record_length;
  assign bytes_used    = head.bytes_used;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
  import lpur_pkg::*;

  // Parser position inside the record stream
  typedef enum logic [1:0] {
    AT_LEN_LO,
    AT_LEN_HI,
    IN_PAYLOAD,
    SKIPPING
  } parse_phase_t;

  // One directed stimulus row; typed rows carry a hand-written expectation
  typedef struct packed {
    logic [7:0] b;
    logic       eod;
    logic       typed;
    result_t    want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 27;
  localparam int BYTES_PER_MIX = 256;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        end_of_data = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        record_end;
  logic [2:0]  status;
  logic [15:0] record_length;
  logic [16:0] bytes_used;

  length_prefixed_utf8_string_reader_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .end_of_data   (end_of_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_byte  (payload_byte),
    .payload_valid (payload_valid),
    .record_end    (record_end),
    .status        (status),
    .record_length (record_length),
    .bytes_used    (bytes_used)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Local copy of the parser: register, header/payload tracking, UTF-8 state
  // ---------------------------------------------------------------------------
  logic [15:0]  max_len = MAX_LEN_RESET;
  parse_phase_t phase = AT_LEN_LO;
  logic [7:0]   len_lo = '0;
  logic [15:0]  rec_len = '0;
  logic [15:0]  byte_count = '0;
  logic [1:0]   cont_left = '0;
  rule_t        sec_rule = RULE_NONE;
  logic         bad_utf8 = 1'b0;
  logic         saw_nul = 1'b0;

  result_t   pending_results[$];   // results owed by the block, oldest first
  logic [7:0] rec_bytes[$];        // header + body of the record being built
  stim_row_t directed [DIRECTED_ROWS];

  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;       // bytes accepted by the block, skipped ones included
  int records_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  logic [15:0] rand_limit;

  function automatic result_t close_result(logic [2:0] st, logic [15:0] len,
                                           logic [16:0] used);
    result_t r;
    r = '0;
    r.record_end = 1'b1;
    r.status = st;
    r.record_length = len;
    r.bytes_used = used;
    return r;
  endfunction

  function automatic stim_row_t row(logic [7:0] b, logic eod);
    return {b, eod, 1'b0, result_t'('0)};
  endfunction

  function automatic stim_row_t row_end(logic [7:0] b, logic eod, logic [2:0] st,
                                        logic [15:0] len, logic [16:0] used);
    return {b, eod, 1'b1, close_result(st, len, used)};
  endfunction

  // UTF-8 well-formedness tracking; decoding stops at the first error,
  // NUL detection does not
  function void utf8_track(logic [7:0] b);
    logic bad;
    if (b == 8'h00) saw_nul = 1'b1;
    if (bad_utf8) return;
    if (cont_left == 0) begin
      sec_rule = RULE_NONE;
      if (b <= ASCII_MAX) begin
        return;
      end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
        cont_left = 2'd1;
      end else if (b[7:4] == 4'hE) begin
        cont_left = 2'd2;
        if (b == LEAD_E0) sec_rule = RULE_E0;
        else if (b == LEAD_ED) sec_rule = RULE_ED;
      end else if (b >= LEAD_F0 && b <= LEAD_F4) begin
        cont_left = 2'd3;
        if (b == LEAD_F0) sec_rule = RULE_F0;
        else if (b == LEAD_F4) sec_rule = RULE_F4;
      end else begin
        bad_utf8 = 1'b1;
      end
      return;
    end
    bad = (b[7:6] != 2'b10);
    if (sec_rule == RULE_E0 && b < E0_SEC_MIN) bad = 1'b1;
    if (sec_rule == RULE_ED && b > ED_SEC_MAX) bad = 1'b1;
    if (sec_rule == RULE_F0 && b < F0_SEC_MIN) bad = 1'b1;
    if (sec_rule == RULE_F4 && b > F4_SEC_MAX) bad = 1'b1;
    sec_rule = RULE_NONE;
    if (bad) begin
      bad_utf8 = 1'b1;
      cont_left = 2'd0;
    end else begin
      cont_left = cont_left - 2'd1;
    end
  endfunction

  // Advance the parser copy by one accepted byte; emits says whether a result follows
  function void parse_byte(input logic [7:0] b, input logic eod,
                           output bit emits, output result_t r);
    logic [2:0] st;
    emits = 1'b0;
    r = '0;
    case (phase)
      AT_LEN_LO: begin
        len_lo = b;
        if (eod) begin
          emits = 1'b1;
          r = close_result(ST_TRUNCATED, 16'd0, 17'd0);
        end else begin
          phase = AT_LEN_HI;
        end
      end
      AT_LEN_HI: begin
        rec_len = {b, len_lo};
        byte_count = '0;
        cont_left = '0;
        sec_rule = RULE_NONE;
        bad_utf8 = 1'b0;
        saw_nul = 1'b0;
        emits = 1'b1;
        // limit check happens here, once per record
        if (rec_len > max_len) begin
          phase = eod ? AT_LEN_LO : SKIPPING;
          r = close_result(ST_TOO_LONG, rec_len, 17'd0);
        end else if (rec_len == 0) begin
          phase = AT_LEN_LO;
          r = close_result(ST_OK, 16'd0, HEADER_BYTES);
        end else if (eod) begin
          phase = AT_LEN_LO;
          r = close_result(ST_TRUNCATED, rec_len, 17'd0);
        end else begin
          phase = IN_PAYLOAD;
          emits = 1'b0;
        end
      end
      IN_PAYLOAD: begin
        utf8_track(b);
        byte_count = byte_count + 16'd1;
        emits = 1'b1;
        if (byte_count == rec_len) begin
          // NUL outranks malformed UTF-8; an open sequence counts as malformed
          st = ST_OK;
          if (saw_nul) st = ST_NUL;
          else if (bad_utf8 || cont_left != 0) st = ST_BAD_UTF8;
          phase = AT_LEN_LO;
          r = close_result(st, rec_len, {1'b0, rec_len} + HEADER_BYTES);
        end else if (eod) begin
          phase = AT_LEN_LO;
          r = close_result(ST_TRUNCATED, rec_len, 17'd0);
        end
        r.payload_byte = b;
        r.payload_valid = 1'b1;
      end
      default: begin
        if (eod) phase = AT_LEN_LO;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  task send_byte(input logic [7:0] b, input logic eod, input logic typed,
                 input result_t want);
    bit      emits;
    result_t r;
    int      gap;
    in_valid <= 1'b1;
    in_byte <= b;
    end_of_data <= eod;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    parse_byte(b, eod, emits, r);
    if (typed) r = want;
    if (emits) pending_results.push_back(r);
    gap = 0;
    while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold input until every owed result is out
  task drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task set_max_len(input logic [15:0] v);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_len = v;
  endtask

  task add_code_point();
    logic [20:0] c;
    case ($urandom_range(4))
      0, 1: begin
        c = 21'($urandom_range(1, 127));
        rec_bytes.push_back(c[7:0]);
      end
      2: begin
        c = 21'($urandom_range(16'h80, 16'h7FF));
        rec_bytes.push_back({3'b110, c[10:6]});
        rec_bytes.push_back({2'b10, c[5:0]});
      end
      3: begin
        c = 21'($urandom_range(16'h800, 16'hFFFF));
        if (c >= 21'hD800 && c <= 21'hDFFF) c = c - 21'h800;
        rec_bytes.push_back({4'b1110, c[15:12]});
        rec_bytes.push_back({2'b10, c[11:6]});
        rec_bytes.push_back({2'b10, c[5:0]});
      end
      default: begin
        c = 21'($urandom_range(32'h10000, 32'h10FFFF));
        rec_bytes.push_back({5'b11110, c[20:18]});
        rec_bytes.push_back({2'b10, c[17:12]});
        rec_bytes.push_back({2'b10, c[11:6]});
        rec_bytes.push_back({2'b10, c[5:0]});
      end
    endcase
  endtask

  // Lead bytes near the class edges followed by second bytes near the rule bounds
  task add_boundary_seq();
    logic [7:0] lead;
    logic [7:0] second;
    int n;
    case ($urandom_range(11))
      0: lead = 8'hC0;
      1: lead = 8'hC1;
      2: lead = LEAD2_MIN;
      3: lead = LEAD2_MAX;
      4: lead = LEAD_E0;
      5: lead = LEAD_ED;
      6: lead = 8'hEF;
      7: lead = LEAD_F0;
      8: lead = LEAD_F4;
      9: lead = 8'hF5;
      10: lead = 8'hFF;
      default: lead = 8'h80;
    endcase
    case ($urandom_range(8))
      0: second = 8'h00;
      1: second = 8'h7F;
      2: second = 8'h80;
      3: second = F4_SEC_MAX;
      4: second = F0_SEC_MIN;
      5: second = ED_SEC_MAX;
      6: second = E0_SEC_MIN;
      7: second = 8'hBF;
      default: second = 8'hC0;
    endcase
    rec_bytes.push_back(lead);
    rec_bytes.push_back(second);
    n = $urandom_range(2);
    repeat (n) rec_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
  endtask

  // One record: mostly clean UTF-8, some boundary sequences, raw noise,
  // planted NULs or corruptions, oversized headers and early end-of-data flags
  task send_record();
    int r;
    int len;
    int style;
    int flag_at;
    int last;
    logic [15:0] hdr;
    records_sent++;
    r = $urandom_range(99);
    if (r < 6) len = 0;
    else if (r < 88) len = $urandom_range(1, 8);
    else if (r < 97) len = $urandom_range(9, 40);
    else len = $urandom_range(100, 400);
    if (max_len != 16'hFFFF && $urandom_range(99) < 8)
      len = $urandom_range(int'(max_len) + 1, 65535);
    hdr = len[15:0];
    rec_bytes.delete();
    rec_bytes.push_back(hdr[7:0]);
    rec_bytes.push_back(hdr[15:8]);
    flag_at = -1;
    if (hdr > max_len) begin
      // everything after the header is dropped up to the flagged byte
      repeat ($urandom_range(5)) rec_bytes.push_back(8'($urandom_range(255)));
      flag_at = rec_bytes.size() - 1;
    end else begin
      style = $urandom_range(99);
      while (rec_bytes.size() < len + 2) begin
        if (style >= 55 && style < 70 && $urandom_range(2) == 0) add_boundary_seq();
        else if (style >= 70 && style < 85) rec_bytes.push_back(8'($urandom_range(255)));
        else add_code_point();
      end
      // cutting at the length leaves some multi-byte sequences unfinished
      while (rec_bytes.size() > len + 2) void'(rec_bytes.pop_back());
      if (style >= 85 && len > 0)
        rec_bytes[2 + $urandom_range(len - 1)] =
          ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(255));
      r = $urandom_range(99);
      if (r < 15) flag_at = rec_bytes.size() - 1;
      else if (r < 30) flag_at = $urandom_range(rec_bytes.size() - 1);
    end
    last = (flag_at >= 0) ? flag_at : rec_bytes.size() - 1;
    for (int i = 0; i <= last; i++)
      send_byte(rec_bytes[i], i == flag_at, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall, in-order field compare
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function void check_field(string name, logic [16:0] want, logic [16:0] seen);
    if (seen !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: byte %0h end %0b status %0d len %0h",
                 $time, payload_byte, record_end, status, record_length);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        check_field("payload_byte", 17'(want.payload_byte), 17'(payload_byte));
        check_field("payload_valid", 17'(want.payload_valid), 17'(payload_valid));
        check_field("record_end", 17'(want.record_end), 17'(record_end));
        check_field("status", 17'(want.status), 17'(status));
        check_field("record_length", 17'(want.record_length), 17'(record_length));
        check_field("bytes_used", want.bytes_used, bytes_used);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int start;
    int mix_idle[4];
    int mix_stall[4];
    logic [15:0] mix_limit[4];

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, length limit 4
    directed = '{
      // header FFFF over the limit, then skip through the flag (a NUL, ignored)
      row(8'hFF, 1'b0),
      row_end(8'hFF, 1'b0, ST_TOO_LONG, 16'hFFFF, 17'd0),
      row(8'h00, 1'b1),
      // empty record right after the resync
      row(8'h00, 1'b0),
      row_end(8'h00, 1'b0, ST_OK, 16'd0, 17'd2),
      // flag on the low header byte: no length known
      row_end(8'h07, 1'b1, ST_TRUNCATED, 16'd0, 17'd0),
      // flag on the high header byte
      row(8'h02, 1'b0),
      row_end(8'h00, 1'b1, ST_TRUNCATED, 16'd2, 17'd0),
      // surrogate then NUL: the NUL wins
      row(8'h04, 1'b0), row(8'h00, 1'b0),
      row(8'hED, 1'b0), row(8'hA0, 1'b0), row(8'h00, 1'b0), row(8'h80, 1'b0),
      // F4 90 is past U+10FFFF; flag on the closing byte does not truncate
      row(8'h03, 1'b0), row(8'h00, 1'b0),
      row(8'hF4, 1'b0), row(8'h90, 1'b0), row(8'hFF, 1'b1),
      // flag inside the payload: byte still passes through
      row(8'h03, 1'b0), row(8'h00, 1'b0), row(8'hE2, 1'b0), row(8'h82, 1'b1),
      // sequence left open at the end of the payload
      row(8'h02, 1'b0), row(8'h00, 1'b0), row(8'h41, 1'b0), row(8'hE0, 1'b0)
    };
    set_max_len(16'd4);
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_byte(directed[i].b, directed[i].eod, directed[i].typed, directed[i].want);
    drain();

    // Random part: four idle and stall mixes, each under its own length limit
    rand_limit = 16'($urandom_range(65535));
    mix_idle = '{0, 87, 0, 19};
    mix_stall = '{0, 0, 87, 19};
    mix_limit = '{16'hFFFF, 16'h0000, 16'($urandom_range(2, 30)), rand_limit};
    for (int m = 0; m < 4; m++) begin
      idle_pct = mix_idle[m];
      stall_pct = mix_stall[m];
      set_max_len(mix_limit[m]);
      start = bytes_sent;
      while (bytes_sent - start < BYTES_PER_MIX) send_record();
      // sender holds off until the block has delivered everything
      drain();
    end

    $display("Run covered %0d bytes in %0d records, %0d results checked",
             bytes_sent, records_sent, results_checked);
    $display("Length limits 4, 65535, 0, %0d and %0d; idle and stall mixes on both sides",
             mix_limit[2], rand_limit);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout waiting for results");
    $display("Mismatches found");
    $finish;
  end

endmodule
